// File: rtl/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types, constants and tables of the MIDI voice allocator.
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int VOICES    = 16;
  localparam int PRESETS   = 8;
  localparam int CHANNELS  = 16;
  localparam int MAX_RES   = 16;

  localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VCNT_W    = $clog2(VOICES + 1);
  localparam int RCNT_W    = $clog2(MAX_RES + 1);

  localparam int FIFO_DEPTH = 2;

  // MIDI command nibbles and controller numbers
  localparam logic [3:0] MIDI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON   = 4'h9;
  localparam logic [3:0] MIDI_CTRL      = 4'hB;
  localparam logic [3:0] MIDI_PROGRAM   = 4'hC;
  localparam logic [6:0] CC_PEDAL       = 7'd64;
  localparam logic [6:0] CC_SOUND_OFF   = 7'd120;
  localparam logic [6:0] CC_NOTES_OFF   = 7'd123;
  localparam logic [6:0] PEDAL_THRESH   = 7'd64;

  localparam logic       OP_MIDI        = 1'b0;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_STOP    = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    CMD_NOTE_ON,
    CMD_NOTE_OFF,
    CMD_PEDAL_UP,
    CMD_ALL_REL,
    CMD_ALL_STOP,
    CMD_FREE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [3:0]        chan;
    logic [6:0]        note;
    logic [6:0]        vel;
    logic [2:0]        patch;
    logic              pedal;
    logic [VIDX_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [3:0] slot;
    action_t    action;
    logic [3:0] chan;
    logic [6:0] note;
    logic [6:0] vel;
    logic [2:0] patch;
    logic       last;
  } res_t;

  typedef logic [2:0] patch_lut_t [128];

  function automatic patch_lut_t build_patch_lut();
    patch_lut_t lut;
    for (int i = 0; i < 128; i++) begin
      lut[i] = 3'(i % PRESETS);
    end
    return lut;
  endfunction

  // program number to reported patch index
  localparam patch_lut_t PATCH_LUT = build_patch_lut();

endpackage

// File: rtl/mva_front.sv
// ----------------------------------------------------------------------------
// mva_front
// Accepts input words, keeps per-channel pedal and patch, and turns each
// word that needs one into a voice-table command for the back end.
// ----------------------------------------------------------------------------
module mva_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_operation,
  input  logic [7:0]     in_status_byte,
  input  logic [6:0]     in_data_one,
  input  logic [6:0]     in_data_two,
  input  logic [3:0]     in_finished_voice,
  output logic           cmd_vld,
  output mva_pkg::cmd_t  cmd,
  input  logic           cmd_rdy
);
  import mva_pkg::*;

  logic [CHANNELS-1:0] pedal_r;
  logic [2:0]          patch_r [CHANNELS];

  logic       accept;
  logic       need_cmd;
  logic [3:0] midi_cmd;
  logic [3:0] chan;
  logic       pedal_wr;
  logic       prog_wr;

  assign midi_cmd = in_status_byte[7:4];
  assign chan     = in_status_byte[3:0];
  assign in_ready = cmd_rdy;
  assign accept   = in_valid && in_ready;
  assign cmd_vld  = accept && need_cmd;

  always_comb begin
    need_cmd   = 1'b0;
    pedal_wr   = 1'b0;
    prog_wr    = 1'b0;
    cmd.kind   = CMD_FREE;
    cmd.chan   = chan;
    cmd.note   = in_data_one;
    cmd.vel    = in_data_two;
    cmd.patch  = patch_r[chan];
    cmd.pedal  = pedal_r[chan];
    cmd.slot   = VIDX_W'(in_finished_voice);
    if (in_operation != OP_MIDI) begin
      need_cmd = (32'(in_finished_voice) < 32'(VOICES));
    end else begin
      case (midi_cmd)
        MIDI_NOTE_OFF: begin
          need_cmd = 1'b1;
          cmd.kind = CMD_NOTE_OFF;
        end
        MIDI_NOTE_ON: begin
          need_cmd = 1'b1;
          cmd.kind = (in_data_two != 7'd0) ? CMD_NOTE_ON : CMD_NOTE_OFF;
        end
        MIDI_CTRL: begin
          if (in_data_one == CC_PEDAL) begin
            pedal_wr = 1'b1;
            need_cmd = (in_data_two < PEDAL_THRESH);
            cmd.kind = CMD_PEDAL_UP;
          end else if (in_data_one == CC_NOTES_OFF) begin
            need_cmd = 1'b1;
            cmd.kind = CMD_ALL_REL;
          end else if (in_data_one == CC_SOUND_OFF) begin
            need_cmd = 1'b1;
            cmd.kind = CMD_ALL_STOP;
          end
        end
        MIDI_PROGRAM: begin
          prog_wr = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pedal_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        patch_r[i] <= 3'd0;
      end
    end else if (accept) begin
      if (pedal_wr) begin
        pedal_r[chan] <= (in_data_two >= PEDAL_THRESH);
      end
      if (prog_wr) begin
        patch_r[chan] <= PATCH_LUT[in_data_one];
      end
    end
  end

endmodule

// File: rtl/mva_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mva_cmd_fifo
// Short command queue between front end and voice walker.
// ----------------------------------------------------------------------------
module mva_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_vld,
  input  mva_pkg::cmd_t push_data,
  output logic          push_rdy,
  output logic          pop_vld,
  output mva_pkg::cmd_t pop_data,
  input  logic          pop
);
  import mva_pkg::*;

  localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t              slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_rdy = (count_r != FCNT_W'(FIFO_DEPTH));
  assign pop_vld  = (count_r != '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop && pop_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        slot_r[wr_ptr_r] <= push_data;
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/mva_walk.sv
// ----------------------------------------------------------------------------
// mva_walk
// Voice table and walker: carries out one command by visiting the voices in
// turn, and delivers the resulting voice commands through an output register.
// ----------------------------------------------------------------------------
module mva_walk (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_vld,
  input  mva_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output mva_pkg::res_t out_res
);
  import mva_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FLUSH} state_t;

  state_t             state_r;
  cmd_t               cur_r;
  logic [VCNT_W-1:0]  idx_r;
  logic               ev_vld_r;
  logic [VIDX_W-1:0]  ev_idx_r;
  logic [3:0]         ev_ch_r;
  logic [6:0]         ev_note_r;
  logic [VOICES-1:0]  busy_r;
  logic [VOICES-1:0]  held_r;
  logic               pend_vld_r;
  res_t               pend_r;
  logic [RCNT_W-1:0]  cnt_r;
  logic               out_vld_r;
  res_t               out_r;

  logic [3:0]         ch_mem   [VOICES];
  logic [6:0]         note_mem [VOICES];

  logic v_busy, v_held, chan_hit;
  logic gen, found, set_busy, clr_busy, set_held, clr_held;
  logic walk_end, emit, out_free, stall, adv, issue;
  logic out_load;
  res_t new_res;
  res_t out_word;

  assign v_busy   = busy_r[ev_idx_r];
  assign v_held   = held_r[ev_idx_r];
  assign chan_hit = v_busy && (ev_ch_r == cur_r.chan);

  always_comb begin
    gen            = 1'b0;
    found          = 1'b0;
    set_busy       = 1'b0;
    clr_busy       = 1'b0;
    set_held       = 1'b0;
    clr_held       = 1'b0;
    new_res.slot   = 4'(ev_idx_r);
    new_res.action = ACT_RELEASE;
    new_res.chan   = ev_ch_r;
    new_res.note   = ev_note_r;
    new_res.vel    = 7'd0;
    new_res.patch  = 3'd0;
    new_res.last   = 1'b0;
    if (state_r == ST_WALK && ev_vld_r) begin
      case (cur_r.kind)
        CMD_NOTE_ON: begin
          if (!v_busy) begin
            gen            = 1'b1;
            found          = 1'b1;
            set_busy       = 1'b1;
            clr_held       = 1'b1;
            new_res.action = ACT_START;
            new_res.chan   = cur_r.chan;
            new_res.note   = cur_r.note;
            new_res.vel    = cur_r.vel;
            new_res.patch  = cur_r.patch;
          end
        end
        CMD_NOTE_OFF: begin
          if (chan_hit && ev_note_r == cur_r.note) begin
            set_held = cur_r.pedal;
            gen      = !cur_r.pedal;
          end
        end
        CMD_PEDAL_UP: begin
          if (chan_hit && v_held) begin
            clr_held = 1'b1;
            gen      = 1'b1;
          end
        end
        CMD_ALL_REL: begin
          if (chan_hit) begin
            clr_held = 1'b1;
            gen      = 1'b1;
          end
        end
        CMD_ALL_STOP: begin
          if (chan_hit) begin
            clr_held       = 1'b1;
            clr_busy       = 1'b1;
            gen            = 1'b1;
            new_res.action = ACT_STOP;
            new_res.chan   = cur_r.chan;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // only the first MAX_RES commands are reported; effects always apply
  assign emit     = gen && (cnt_r < RCNT_W'(MAX_RES));
  assign out_free = !out_vld_r || out_ready;
  assign stall    = emit && pend_vld_r && !out_free;
  assign walk_end = (state_r == ST_WALK) && ev_vld_r &&
                    (found || ev_idx_r == VIDX_W'(VOICES - 1));
  assign adv      = (state_r == ST_WALK) && !stall;
  assign issue    = adv && !walk_end && (idx_r < VCNT_W'(VOICES));
  assign cmd_pop  = (state_r == ST_IDLE) && cmd_vld;

  // move the held result out when a newer one arrives or the walk is over
  assign out_load = (adv && emit && pend_vld_r) ||
                    (state_r == ST_FLUSH && pend_vld_r && out_free);

  // the held result closes the word only when the walk is over
  always_comb begin
    out_word      = pend_r;
    out_word.last = (state_r == ST_FLUSH);
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (adv && set_busy) begin
      ch_mem[ev_idx_r]   <= cur_r.chan;
      note_mem[ev_idx_r] <= cur_r.note;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      ev_vld_r   <= 1'b0;
      busy_r     <= '0;
      held_r     <= '0;
      pend_vld_r <= 1'b0;
      cnt_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_r     <= out_word;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cmd_vld) begin
            if (cmd.kind == CMD_FREE) begin
              busy_r[cmd.slot] <= 1'b0;
              held_r[cmd.slot] <= 1'b0;
            end else begin
              cur_r    <= cmd;
              idx_r    <= '0;
              ev_vld_r <= 1'b0;
              cnt_r    <= '0;
              state_r  <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (adv) begin
            if (set_busy) busy_r[ev_idx_r] <= 1'b1;
            if (clr_busy) busy_r[ev_idx_r] <= 1'b0;
            if (set_held) held_r[ev_idx_r] <= 1'b1;
            if (clr_held) held_r[ev_idx_r] <= 1'b0;
            if (emit) begin
              pend_r     <= new_res;
              pend_vld_r <= 1'b1;
              cnt_r      <= cnt_r + 1'b1;
            end
            if (issue) begin
              ev_vld_r  <= 1'b1;
              ev_idx_r  <= idx_r[VIDX_W-1:0];
              ev_ch_r   <= ch_mem[idx_r[VIDX_W-1:0]];
              ev_note_r <= note_mem[idx_r[VIDX_W-1:0]];
              idx_r     <= idx_r + 1'b1;
            end else begin
              ev_vld_r <= 1'b0;
            end
            if (walk_end) begin
              state_r <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_vld_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            pend_vld_r <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/midi_voice_allocator_core.sv
// ----------------------------------------------------------------------------
// midi_voice_allocator_core
// Polyphonic voice allocator with sustain pedal for MIDI channel messages.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one word per MIDI channel message (in_operation 0)
//   or per voice-finished event (in_operation 1). The out_ channel gives the
//   voice commands a word causes, in voice order, with out_last on the final
//   one; a word that causes nothing gives no output word.
//   Program change, pedal down and ignored messages are absorbed by the front
//   end in the accepting cycle. Other words go to a two-entry command queue.
//   Voice-finished events free their voice from the walker's idle state.
//   Note and controller commands walk the voice table one voice per cycle
//   unless a result waits on a full output. Each result is held back so
//   out_last can be set, and moves to the output register at the next match
//   or once the walk ends. Note on stops the walk at the first free voice.
//   Reset (rst_n low, synchronous) frees every voice, lifts all pedals, sets
//   every channel to patch zero and empties the queue and output register.
//   When the receiver stalls, the walker holds on its next result, the queue
//   fills, and in_ready drops once both queue entries are taken.
// ----------------------------------------------------------------------------
module midi_voice_allocator_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_status_byte,
  input  logic [6:0] in_data_one,
  input  logic [6:0] in_data_two,
  input  logic [3:0] in_finished_voice,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_voice_slot,
  output logic [1:0] out_action,
  output logic [3:0] out_midi_channel,
  output logic [6:0] out_note_number,
  output logic [6:0] out_velocity,
  output logic [2:0] out_patch_index,
  output logic       out_last
);
  import mva_pkg::*;

  // front end to queue
  logic cmd_vld;
  cmd_t cmd;
  logic cmd_rdy;

  // queue to walker
  logic head_vld;
  cmd_t head;
  logic head_pop;

  res_t res;

  mva_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_status_byte    (in_status_byte),
    .in_data_one       (in_data_one),
    .in_data_two       (in_data_two),
    .in_finished_voice (in_finished_voice),
    .cmd_vld           (cmd_vld),
    .cmd               (cmd),
    .cmd_rdy           (cmd_rdy)
  );

  mva_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (cmd_vld),
    .push_data (cmd),
    .push_rdy  (cmd_rdy),
    .pop_vld   (head_vld),
    .pop_data  (head),
    .pop       (head_pop)
  );

  mva_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_vld   (head_vld),
    .cmd       (head),
    .cmd_pop   (head_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // unpack the result word onto the ports
  assign out_voice_slot   = res.slot;
  assign out_action       = res.action;
  assign out_midi_channel = res.chan;
  assign out_note_number  = res.note;
  assign out_velocity     = res.vel;
  assign out_patch_index  = res.patch;
  assign out_last         = res.last;

endmodule

// File: rtl/mva_checker.sv
// ----------------------------------------------------------------------------
// mva_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module mva_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_voice_slot,
  input logic [1:0] out_action,
  input logic [3:0] out_midi_channel,
  input logic [6:0] out_note_number,
  input logic [6:0] out_velocity,
  input logic [2:0] out_patch_index,
  input logic       out_last
);
  import mva_pkg::*;

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result word holds its slot, action, channel, note and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_voice_slot) &&
      $stable(out_action) && $stable(out_midi_channel) &&
      $stable(out_note_number) && $stable(out_last))
    else $error("stalled output word changed");

  // a note start is the only word its message causes
  a_start_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_START |-> out_last)
    else $error("start word not marked last");

  // a start always carries a strike velocity
  a_start_velocity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_START |-> out_velocity != 7'd0)
    else $error("start word with zero velocity");

  // release and stop carry no velocity or patch
  a_release_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_START |->
      out_velocity == 7'd0 && out_patch_index == 3'd0)
    else $error("release or stop word with velocity or patch");

endmodule

bind midi_voice_allocator_core mva_checker u_mva_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_voice_slot   (out_voice_slot),
  .out_action       (out_action),
  .out_midi_channel (out_midi_channel),
  .out_note_number  (out_note_number),
  .out_velocity     (out_velocity),
  .out_patch_index  (out_patch_index),
  .out_last         (out_last)
);
